FILE: sv/dgh_pkg.sv
`default_nettype none
package dgh_pkg;

	// grid geometry
	localparam int GRID_COLUMNS = 5;
	localparam int GRID_ROWS = 7;
	localparam int TABLE_ROWS = 7;

	// glyph geometry
	localparam int GLYPH_W = 3;
	localparam int GLYPH_H = 5;
	localparam int NUM_DIGITS = 10;
	localparam logic [3:0] MAX_DIGIT = 4'd9;
	localparam logic [1:0] LAST_COL = 2'(GLYPH_W - 1);
	localparam logic [2:0] LAST_ROW = 3'(GLYPH_H - 1);

	// one glyph cell on its way from the font read to the index mapping
	typedef struct packed {
		logic [1:0] cx;
		logic [2:0] cy;
		logic [2:0] ox;
		logic [2:0] oy;
		logic       last;
	} cell_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	// per-row strip tables
	function automatic logic [2:0] row_len(input logic [2:0] gy);
		logic [2:0] len;
		case (gy)
			3'd0: len = 3'd3;
			3'd1: len = 3'd4;
			3'd2: len = 3'd5;
			3'd3: len = 3'd4;
			3'd4: len = 3'd5;
			3'd5: len = 3'd4;
			3'd6: len = 3'd3;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [4:0] row_off(input logic [2:0] gy);
		logic [4:0] off;
		case (gy)
			3'd0: off = 5'd1;
			3'd1: off = 5'd4;
			3'd2: off = 5'd8;
			3'd3: off = 5'd13;
			3'd4: off = 5'd17;
			3'd5: off = 5'd22;
			3'd6: off = 5'd26;
			default: off = 5'd0;
		endcase
		return off;
	endfunction

	function automatic logic row_ind(input logic [2:0] gy);
		logic ind;
		case (gy)
			3'd0: ind = 1'b1;
			3'd6: ind = 1'b1;
			default: ind = 1'b0;
		endcase
		return ind;
	endfunction

endpackage
`default_nettype wire

FILE: sv/dgh_font_rom.sv
`default_nettype none
module dgh_font_rom (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [3:0] digit,
	input  wire logic [2:0] row,
	output      logic [2:0] bits_q
);
	import dgh_pkg::*;

	// bit 2 is the leftmost glyph column
	localparam logic [2:0] FONT [NUM_DIGITS][GLYPH_H] = '{
		'{3'd6, 3'd5, 3'd0, 3'd5, 3'd6},
		'{3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
		'{3'd6, 3'd5, 3'd2, 3'd2, 3'd7},
		'{3'd6, 3'd5, 3'd2, 3'd5, 3'd6},
		'{3'd4, 3'd5, 3'd6, 3'd1, 3'd2},
		'{3'd6, 3'd4, 3'd6, 3'd1, 3'd6},
		'{3'd2, 3'd2, 3'd6, 3'd5, 3'd6},
		'{3'd6, 3'd1, 3'd2, 3'd2, 3'd4},
		'{3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
		'{3'd6, 3'd5, 3'd6, 3'd2, 3'd4}
	};

	always_ff @(posedge clk) begin
		if (en) begin
			bits_q <= FONT[digit][row];
		end
	end

endmodule
`default_nettype wire

FILE: sv/dgh_cell_map.sv
`default_nettype none
module dgh_cell_map (
	input  wire logic [2:0]     glyph_row,
	input  wire dgh_pkg::cell_t glyph_cell,
	output      logic           write_enable,
	output      logic [4:0]     pixel_index
);
	import dgh_pkg::*;

	logic [3:0] gx;
	logic [3:0] gy;
	logic       lit;
	logic       on_grid;
	logic       in_span;
	logic       ind;
	logic [2:0] len;
	logic [4:0] off;
	logic [3:0] span_end;
	logic [3:0] col;
	logic [3:0] pos;
	logic [5:0] sum;

	always_comb begin
		gx = {1'b0, glyph_cell.ox} + {2'b0, glyph_cell.cx};
		gy = {1'b0, glyph_cell.oy} + {1'b0, glyph_cell.cy};
		// bit 2 is the leftmost column
		lit = glyph_row[2'd2 - glyph_cell.cx];
		on_grid = ({2'b0, gx} < 6'(GRID_COLUMNS)) && ({2'b0, gy} < 6'(GRID_ROWS))
			&& ({2'b0, gy} < 6'(TABLE_ROWS));
		ind = row_ind(gy[2:0]);
		len = row_len(gy[2:0]);
		off = row_off(gy[2:0]);
		span_end = {3'b0, ind} + {1'b0, len};
		in_span = (gx >= {3'b0, ind}) && (gx < span_end);
		col = gx - {3'b0, ind};
		// odd rows run right to left
		if (gy[0]) begin
			pos = {1'b0, len} - 4'd1 - col;
		end else begin
			pos = col;
		end
		sum = {1'b0, off} + {2'b0, pos};
		write_enable = lit && on_grid && in_span;
		pixel_index = write_enable ? sum[4:0] : 5'd0;
	end

endmodule
`default_nettype wire

FILE: sv/digit_glyph_to_hex_strip.sv
`default_nettype none
// draws one decimal digit from a 3x5 font onto a hexagonal led grid wired as a
// serpentine strip. each accepted request yields fifteen results, one per glyph
// cell, column by column and top to bottom within a column; the fifteenth
// carries last. a result writes a pixel only when its glyph bit is lit and the
// cell lies inside its grid row's span; pixel_index is then the strip position
// (odd rows reversed), otherwise 0. digits above nine draw a nine, and the
// colour is copied onto every result. throughput is one result per cycle while the
// output is not stalled; the single font rom port is read once per cell, and
// the next request is taken in the cycle the last cell of the current one is
// read. the first result follows the request through the request register,
// the font rom read and the output register, in that order. a stalled output
// holds the whole pipe in place.
module digit_glyph_to_hex_strip (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [3:0] digit,
	input  wire logic [2:0] origin_x,
	input  wire logic [2:0] origin_y,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic       write_enable,
	output      logic [4:0] pixel_index,
	output      logic [7:0] out_red,
	output      logic [7:0] out_green,
	output      logic [7:0] out_blue,
	output      logic       last
);
	import dgh_pkg::*;

	// current request and cell counters
	logic       busy_q;
	logic [3:0] digit_q;
	logic [2:0] ox_q;
	logic [2:0] oy_q;
	colour_t    colour_q;
	logic [1:0] cx_q;
	logic [2:0] cy_q;

	// font read stage
	logic       valid_s1;
	cell_t      cell_s1;
	colour_t    colour_s1;
	logic [2:0] glyph_s1;

	// output register
	logic       out_valid_q;
	logic       we_q;
	logic [4:0] idx_q;
	colour_t    out_colour_q;
	logic       last_q;

	logic       adv;
	logic       issue;
	logic       last_cell;
	logic       accept;
	logic       map_we;
	logic [4:0] map_idx;
	cell_t      cell_next;

	// the pipe moves whenever the output register is empty or being drained
	assign adv = !out_valid_q || out_ready;
	assign issue = busy_q && adv;
	assign last_cell = (cx_q == LAST_COL) && (cy_q == LAST_ROW);
	assign in_ready = !busy_q || (issue && last_cell);
	assign accept = in_valid && in_ready;

	always_comb begin
		cell_next.cx = cx_q;
		cell_next.cy = cy_q;
		cell_next.ox = ox_q;
		cell_next.oy = oy_q;
		cell_next.last = last_cell;
	end

	// request register and cell walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cx_q <= 2'd0;
			cy_q <= 3'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cx_q <= 2'd0;
			cy_q <= 3'd0;
		end else if (issue) begin
			if (last_cell) begin
				busy_q <= 1'b0;
			end
			if (cy_q == LAST_ROW) begin
				cy_q <= 3'd0;
				cx_q <= cx_q + 2'd1;
			end else begin
				cy_q <= cy_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// saturate to nine
			digit_q <= (digit > MAX_DIGIT) ? MAX_DIGIT : digit;
			ox_q <= origin_x;
			oy_q <= origin_y;
			colour_q <= '{red: red, green: green, blue: blue};
		end
	end

	// font rom, one glyph row per cell
	dgh_font_rom u_font (
		.clk    (clk),
		.en     (issue),
		.digit  (digit_q),
		.row    (cy_q),
		.bits_q (glyph_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cell_s1 <= cell_next;
			colour_s1 <= colour_q;
		end
	end

	// grid to strip mapping
	dgh_cell_map u_map (
		.glyph_row    (glyph_s1),
		.glyph_cell   (cell_s1),
		.write_enable (map_we),
		.pixel_index  (map_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			we_q <= map_we;
			idx_q <= map_idx;
			out_colour_q <= colour_s1;
			last_q <= cell_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign write_enable = we_q;
	assign pixel_index = idx_q;
	assign out_red = out_colour_q.red;
	assign out_green = out_colour_q.green;
	assign out_blue = out_colour_q.blue;
	assign last = last_q;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	// one request as it goes into the block
	typedef struct packed {
		logic [3:0] digit;
		logic [2:0] ox;
		logic [2:0] oy;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} digit_req_t;

	// one glyph position as it comes out of the block
	typedef struct packed {
		logic       we;
		logic [4:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} strip_write_t;

	// strip layout per grid row, row 0 in the lowest slot
	localparam logic [6:0][2:0] ROW_SPAN   = {3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3};
	localparam logic [6:0][4:0] ROW_BASE   = {5'd26, 5'd22, 5'd17, 5'd13, 5'd8, 5'd4, 5'd1};
	localparam logic [6:0]      ROW_INDENT = 7'b1000001;
	localparam int              ROW_TABLE  = 7;
	localparam int              DRAIN_WAIT = 12;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] digit = '0;
	logic [2:0] origin_x = '0;
	logic [2:0] origin_y = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       write_enable;
	logic [4:0] pixel_index;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last;

	// expected glyph writes, oldest first
	strip_write_t expected_writes[$];

	int error_count = 0;
	int requests_sent = 0;
	int writes_checked = 0;
	int pixels_lit = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold_cycles = 0;

	digit_glyph_to_hex_strip DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.digit        (digit),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.pixel_index  (pixel_index),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.last         (last)
	);

	always #1 clk = ~clk;

	// font rows packed top row first, bit 2 of each row is the left column
	function automatic logic [14:0] glyph_pattern(input logic [3:0] d);
		logic [14:0] pat;
		case (d)
			4'd0: pat = {3'd6, 3'd5, 3'd0, 3'd5, 3'd6};
			4'd1: pat = {3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
			4'd2: pat = {3'd6, 3'd5, 3'd2, 3'd2, 3'd7};
			4'd3: pat = {3'd6, 3'd5, 3'd2, 3'd5, 3'd6};
			4'd4: pat = {3'd4, 3'd5, 3'd6, 3'd1, 3'd2};
			4'd5: pat = {3'd6, 3'd4, 3'd6, 3'd1, 3'd6};
			4'd6: pat = {3'd2, 3'd2, 3'd6, 3'd5, 3'd6};
			4'd7: pat = {3'd6, 3'd1, 3'd2, 3'd2, 3'd4};
			4'd8: pat = {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
			// nine, and every digit above nine saturates to it
			default: pat = {3'd6, 3'd5, 3'd6, 3'd2, 3'd4};
		endcase
		return pat;
	endfunction

	// works out the fifteen strip writes of one request and queues them
	task automatic predict_strip_writes(input digit_req_t req);
		logic [14:0]  pat;
		logic [2:0]   glyph_row;
		strip_write_t w;
		int           gx;
		int           gy;
		int           span_pos;
		pat = glyph_pattern(req.digit);
		for (int cx = 0; cx < dgh_pkg::GLYPH_W; cx++) begin
			for (int cy = 0; cy < dgh_pkg::GLYPH_H; cy++) begin
				glyph_row = pat[14 - 3 * cy -: 3];
				gx = int'(req.ox) + cx;
				gy = int'(req.oy) + cy;
				w = '0;
				w.red = req.red;
				w.green = req.green;
				w.blue = req.blue;
				w.last = (cx == dgh_pkg::GLYPH_W - 1) && (cy == dgh_pkg::GLYPH_H - 1);
				// unlit bits and cells off the grid or outside the row span write nothing
				if (glyph_row[2 - cx] && gx < dgh_pkg::GRID_COLUMNS &&
				    gy < dgh_pkg::GRID_ROWS && gy < ROW_TABLE) begin
					span_pos = gx - int'(ROW_INDENT[gy]);
					if (span_pos >= 0 && span_pos < int'(ROW_SPAN[gy])) begin
						w.we = 1'b1;
						// odd rows of the serpentine run right to left
						if (gy % 2 == 0)
							w.idx = 5'(int'(ROW_BASE[gy]) + span_pos);
						else
							w.idx = 5'(int'(ROW_BASE[gy]) + int'(ROW_SPAN[gy]) - 1 - span_pos);
					end
				end
				expected_writes.push_back(w);
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// offers one request, after a random idle gap, and returns once it is taken
	task automatic send_request(input digit_req_t req);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		digit <= req.digit;
		origin_x <= req.ox;
		origin_y <= req.oy;
		red <= req.red;
		green <= req.green;
		blue <= req.blue;
		do @(posedge clk); while (!in_ready);
		predict_strip_writes(req);
		requests_sent++;
	endtask

	// sender goes quiet until every expected write has come out
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// origins lean towards the visible part of the grid but cover all of it
	function automatic digit_req_t random_request();
		digit_req_t req;
		req.digit = 4'($urandom_range(15));
		req.ox = ($urandom_range(3) != 0) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
		req.oy = ($urandom_range(3) != 0) ? 3'($urandom_range(6)) : 3'($urandom_range(7));
		req.red = 8'($urandom_range(255));
		req.green = 8'($urandom_range(255));
		req.blue = 8'($urandom_range(255));
		return req;
	endfunction

	// every digit code, saturated ones included, placed mostly in full view
	task automatic test_every_digit();
		digit_req_t req;
		for (int d = 0; d < 16; d++) begin
			req.digit = 4'(d);
			req.ox = 3'(d % 3);
			req.oy = 3'(d % 3);
			req.red = 8'(d * 17);
			req.green = ~8'(d * 17);
			req.blue = {4'(d), ~4'(d)};
			send_request(req);
		end
		wait_for_drain();
	endtask

	// corner origins push the glyph off the grid and across the indented rows
	task automatic test_origin_extremes();
		digit_req_t req;
		logic [2:0] corner_x[6] = '{3'd0, 3'd7, 3'd0, 3'd7, 3'd4, 3'd2};
		logic [2:0] corner_y[6] = '{3'd0, 3'd7, 3'd7, 3'd0, 3'd6, 3'd2};
		logic [7:0] shade[4] = '{8'hFF, 8'h00, 8'hAA, 8'h55};
		for (int i = 0; i < 6; i++) begin
			req.digit = 4'd8;
			req.ox = corner_x[i];
			req.oy = corner_y[i];
			req.red = shade[i % 4];
			req.green = shade[(i + 1) % 4];
			req.blue = shade[(i + 2) % 4];
			send_request(req);
		end
		wait_for_drain();
	endtask

	// random requests under one idle and stall setting, then a full drain
	task automatic test_random_phase(input int send_idle, input int recv_stall,
	                                 input int count);
		sender_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		for (int i = 0; i < count; i++)
			send_request(random_request());
		wait_for_drain();
	endtask

	// receiver holds off long enough for the pipe to fill and stall the input
	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold_cycles = 300;
		for (int i = 0; i < 10; i++)
			send_request(random_request());
		wait_for_drain();
	endtask

	// receiver side: a counted hold-off first, otherwise random stalls
	always @(posedge clk) begin
		if (recv_hold_cycles > 0) begin
			out_ready <= 1'b0;
			recv_hold_cycles <= recv_hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// checks every accepted write against the oldest expectation
	always @(posedge clk) begin
		strip_write_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_writes.size() == 0) begin
				report_mismatch("write with no request outstanding");
			end else begin
				exp_w = expected_writes.pop_front();
				writes_checked++;
				if (exp_w.we)
					pixels_lit++;
				if (write_enable !== exp_w.we)
					report_mismatch($sformatf("write_enable %b, expected %b",
					                          write_enable, exp_w.we));
				if (pixel_index !== exp_w.idx)
					report_mismatch($sformatf("pixel_index %0d, expected %0d",
					                          pixel_index, exp_w.idx));
				if (out_red !== exp_w.red)
					report_mismatch($sformatf("out_red %h, expected %h", out_red, exp_w.red));
				if (out_green !== exp_w.green)
					report_mismatch($sformatf("out_green %h, expected %h",
					                          out_green, exp_w.green));
				if (out_blue !== exp_w.blue)
					report_mismatch($sformatf("out_blue %h, expected %h", out_blue, exp_w.blue));
				if (last !== exp_w.last)
					report_mismatch($sformatf("last %b, expected %b", last, exp_w.last));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_every_digit();
		test_origin_extremes();
		// no idling, idle sender, stalling receiver, then a little of both
		test_random_phase(0, 0, 75);
		test_random_phase(80, 0, 75);
		test_random_phase(0, 80, 75);
		test_random_phase(16, 16, 75);
		test_output_backpressure();

		if (expected_writes.size() != 0)
			report_mismatch($sformatf("%0d writes never arrived", expected_writes.size()));

		$display("drew %0d digit requests, checked %0d glyph writes (%0d lit pixels)",
		         requests_sent, writes_checked, pixels_lit);
		$display("covered all digit codes, grid corners, idle and stall phases, long hold-off");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// safety net should the handshake hang
	initial begin
		#1_000_000;
		$display("timeout with %0d writes outstanding", expected_writes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
sv/dgh_pkg.sv
sv/dgh_font_rom.sv
sv/dgh_cell_map.sv
sv/digit_glyph_to_hex_strip.sv
bench/testbench.sv
